// ----- src/ptdt_pkg.sv -----
// Package for the periodic task dispatch table: request and status codes,
// payload structs, controller states and controller/datapath command types.
// No dependencies.
package ptdt_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;

  // A stored use time at or above this raises the warning flag.
  localparam logic [31:0] USE_WARN_MIN = 32'h0000_0001;

  // Request codes; 5 to 7 are unused and answer a plain ok.
  localparam logic [2:0] REQ_CREATE = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_TICK   = 3'd2;
  localparam logic [2:0] REQ_DONE   = 3'd3;
  localparam logic [2:0] REQ_QUERY  = 3'd4;

  // Result status codes.
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_DISPATCH = 2'd2;
  localparam logic [1:0] STS_SCAN_END = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] task_key;
    logic [15:0] delay;
    logic [3:0]  slot;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [31:0] interval_out;
    logic [31:0] use_time_out;
    logic [15:0] delay_out;
    logic        valid_out;
    logic        warn;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_TICK,
    S_END,
    S_SIMPLE
  } state_e;

  typedef enum logic [1:0] {
    OP_CREATE,
    OP_DISPATCH,
    OP_END,
    OP_SIMPLE
  } op_e;

  typedef struct packed {
    logic load;     // capture the accepted request
    logic clr_idx;  // restart the slot walk at slot 0
    logic inc_idx;  // advance to the next slot
    logic fire;     // update the table and load the result register
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;       // current slot matches (create) or is due (tick)
    logic at_last;   // walk sits on the last slot
    logic out_free;  // result register can take a new result this cycle
  } dp_sts_t;

endpackage

// ----- src/ptdt_ctrl.sv -----
// Controller for the periodic task dispatch table: sequences the slot walk
// for create and tick and the single-step requests. Uses ptdt_pkg.
module ptdt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  ptdt_pkg::dp_sts_t  sts_i,
  output ptdt_pkg::dp_cmd_t  cmd_o
);
  import ptdt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (req_type_i)
            REQ_CREATE: state_d = S_CREATE;
            REQ_TICK:   state_d = S_TICK;
            default:    state_d = S_SIMPLE;
          endcase
        end
      end
      S_CREATE: begin
        if (sts_i.out_free && (sts_i.hit || sts_i.at_last)) state_d = S_IDLE;
      end
      S_TICK: begin
        if (sts_i.at_last && (!sts_i.hit || sts_i.out_free)) state_d = S_END;
      end
      S_END, S_SIMPLE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.op      = OP_SIMPLE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i;
        cmd_o.clr_idx = in_valid_i;
      end
      S_CREATE: begin
        cmd_o.op      = OP_CREATE;
        cmd_o.fire    = sts_i.out_free && (sts_i.hit || sts_i.at_last);
        cmd_o.inc_idx = !sts_i.hit && !sts_i.at_last;
      end
      S_TICK: begin
        cmd_o.op      = OP_DISPATCH;
        cmd_o.fire    = sts_i.hit && sts_i.out_free;
        cmd_o.inc_idx = !sts_i.hit || sts_i.out_free;
      end
      S_END: begin
        cmd_o.op   = OP_END;
        cmd_o.fire = sts_i.out_free;
      end
      S_SIMPLE: begin
        cmd_o.op   = OP_SIMPLE;
        cmd_o.fire = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/ptdt_data.sv -----
// Datapath for the periodic task dispatch table: request register, slot
// walk index, slot storage with one read address, result register.
// Uses ptdt_pkg; driven by ptdt_ctrl commands.
module ptdt_data #(
  parameter int unsigned NUM_SLOTS = ptdt_pkg::NUM_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptdt_pkg::req_t     in_data_i,
  input  ptdt_pkg::dp_cmd_t  cmd_i,
  output ptdt_pkg::dp_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptdt_pkg::rsp_t     out_data_o
);
  import ptdt_pkg::*;

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  req_t              req_q;
  logic [IDX_W-1:0]  idx_q;
  logic              out_valid_q;
  rsp_t              out_q, rsp_d;

  // slot table; only valid and busy need reset, an invalid slot reads as zero
  logic [NUM_SLOTS-1:0] valid_q, busy_q;
  logic [31:0]          key_q      [NUM_SLOTS];
  logic [15:0]          delay_q    [NUM_SLOTS];
  logic [31:0]          last_q     [NUM_SLOTS];
  logic [31:0]          interval_q [NUM_SLOTS];
  logic [31:0]          use_q      [NUM_SLOTS];

  logic [31:0]      slot_ext, idx_ext;
  logic             slot_ok;
  logic [IDX_W-1:0] addr;
  logic             rd_valid, rd_busy;
  logic [31:0]      rd_key, rd_last, rd_interval, rd_use;
  logic [15:0]      rd_delay;
  logic [31:0]      elapsed, done_use;
  logic             create_hit, due;
  logic             wr_fill, wr_dispatch, wr_done, wr_delete;

  assign slot_ext = {28'd0, req_q.slot};
  assign idx_ext  = 32'(idx_q);
  assign slot_ok  = slot_ext < 32'(NUM_SLOTS);
  assign addr     = (cmd_i.op == OP_SIMPLE) ? slot_ext[IDX_W-1:0] : idx_q;

  assign rd_valid    = valid_q[addr];
  assign rd_busy     = busy_q[addr];
  assign rd_key      = key_q[addr];
  assign rd_delay    = rd_valid ? delay_q[addr]    : 16'd0;
  assign rd_last     = last_q[addr];
  assign rd_interval = rd_valid ? interval_q[addr] : 32'd0;
  assign rd_use      = rd_valid ? use_q[addr]      : 32'd0;

  assign elapsed    = req_q.now - rd_last;   // wraps mod 2^32
  assign create_hit = !rd_valid || (rd_key == req_q.task_key);
  assign due        = rd_valid && !rd_busy && (elapsed >= {16'd0, rd_delay});
  assign done_use   = (rd_valid && rd_busy) ? elapsed : rd_use;

  assign sts_o.hit      = (cmd_i.op == OP_CREATE) ? create_hit : due;
  assign sts_o.at_last  = (idx_q == LAST_IDX);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign wr_fill     = cmd_i.fire && (cmd_i.op == OP_CREATE) && !rd_valid;
  assign wr_dispatch = cmd_i.fire && (cmd_i.op == OP_DISPATCH);
  assign wr_done     = cmd_i.fire && (cmd_i.op == OP_SIMPLE) && slot_ok &&
                       (req_q.req_type == REQ_DONE) && rd_valid && rd_busy;
  assign wr_delete   = cmd_i.fire && (cmd_i.op == OP_SIMPLE) && slot_ok &&
                       (req_q.req_type == REQ_DELETE);

  // result of the current step
  always_comb begin
    rsp_d = '0;
    case (cmd_i.op)
      OP_CREATE: begin
        rsp_d.last = 1'b1;
        if (create_hit) begin
          rsp_d.status   = STS_OK;
          rsp_d.slot_out = idx_ext[3:0];
        end else begin
          rsp_d.status = STS_FULL;
        end
      end
      OP_DISPATCH: begin
        rsp_d.status       = STS_DISPATCH;
        rsp_d.slot_out     = idx_ext[3:0];
        rsp_d.interval_out = elapsed;
      end
      OP_END: begin
        rsp_d.status = STS_SCAN_END;
        rsp_d.last   = 1'b1;
      end
      default: begin
        rsp_d.last = 1'b1;
        case (req_q.req_type)
          REQ_DELETE: rsp_d.slot_out = req_q.slot;
          REQ_DONE: begin
            rsp_d.slot_out = req_q.slot;
            if (slot_ok) begin
              rsp_d.use_time_out = done_use;
              rsp_d.warn         = done_use >= USE_WARN_MIN;
            end
          end
          REQ_QUERY: begin
            rsp_d.slot_out = req_q.slot;
            if (slot_ok) begin
              rsp_d.interval_out = rd_interval;
              rsp_d.use_time_out = rd_use;
              rsp_d.delay_out    = rd_delay;
              rsp_d.valid_out    = rd_valid;
              rsp_d.warn         = rd_use >= USE_WARN_MIN;
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      busy_q      <= '0;
    end else begin
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_fill) begin
        valid_q[addr] <= 1'b1;
        busy_q[addr]  <= 1'b0;
      end
      if (wr_dispatch) begin
        busy_q[addr] <= 1'b1;
      end
      if (wr_done || wr_delete) begin
        busy_q[addr] <= 1'b0;
      end
      if (wr_delete) begin
        valid_q[addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.fire) begin
      out_q <= rsp_d;
    end
    if (wr_fill) begin
      key_q[addr]      <= req_q.task_key;
      delay_q[addr]    <= req_q.delay;
      last_q[addr]     <= '0;
      interval_q[addr] <= '0;
      use_q[addr]      <= '0;
    end
    if (wr_dispatch) begin
      interval_q[addr] <= elapsed;
      last_q[addr]     <= req_q.now;
    end
    if (wr_done) begin
      use_q[addr]  <= elapsed;
      last_q[addr] <= req_q.now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a new result never overwrites one that is still waiting
  a_fire_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // only a valid, idle slot is dispatched
  a_dispatch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_dispatch |-> (rd_valid && !rd_busy))
    else $error("dispatch of invalid or busy slot");

  // dispatch results are never the final result of a tick
  a_dispatch_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == STS_DISPATCH)) |-> !out_q.last)
    else $error("dispatch result marked last");

  // a busy slot is always a valid one
  a_busy_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q & ~valid_q) == '0)
    else $error("busy bit set on free slot");

endmodule

// ----- src/periodic_task_dispatch_table.sv -----
// Periodic task dispatch table. Create walks slots in order, one per cycle,
// to the first matching or free slot or the last slot. Tick walks every slot,
// holding on a due slot until the result register is free, then gives a scan
// end result. Delete, done, query are single steps. One request at a time.
// Reset (rst_ni low, async) frees all slots and clears busy bits and handshakes.
module periodic_task_dispatch_table #(
  parameter int unsigned NUM_SLOTS = ptdt_pkg::NUM_SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ptdt_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ptdt_pkg::rsp_t  out_data_o
);
  import ptdt_pkg::*;

  // Controller and datapath talk only through these two bundles.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sees the request type on the input bus so it can pick
  // the walk (create, tick) or single step path in the accept cycle. The
  // request is latched in the datapath at the same edge.
  ptdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (in_data_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Slot table, walk index and a one-entry result register. The result
  // register lets the next request be taken while a result still waits;
  // during a tick the walk holds on a due slot until that register is free.
  ptdt_data #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_data (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
